FILE: rtl/core/ntc_a2c_pkg.sv
package ntc_a2c_pkg;

  localparam int unsigned RefW   = 13;
  localparam int unsigned OhmW   = 20;
  localparam int unsigned BetaW  = 14;
  localparam int unsigned TempW  = 19;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  // Products of resistor and divider voltage, and their log2 in Q.16.
  localparam int unsigned ProdW  = OhmW + RefW;
  localparam int unsigned ExpW   = 6;
  localparam int unsigned FracW  = 16;
  localparam int unsigned LogW   = ExpW + FracW;

  // Quotient bits kept by the divider; anything larger saturates anyway.
  localparam int unsigned QuotW  = 18;

  localparam logic [24:0] KT0Ln2   = 25'd13543790;
  localparam logic [14:0] T0Centi  = 15'd29815;
  localparam logic signed [TempW-1:0] ZeroCCenti = 19'sd27315;
  localparam logic signed [TempW-1:0] TempMax    = 19'sd150000;
  localparam logic signed [TempW-1:0] TempMin    = -19'sd27315;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRefMv   = 3'd0,
    CfgRfix    = 3'd1,
    CfgR25     = 3'd2,
    CfgBeta    = 3'd3,
    CfgOnTop   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [RefW-1:0]  ref_mv;
    logic [OhmW-1:0]  rfix;
    logic [OhmW-1:0]  r25;
    logic [BetaW-1:0] beta;
    logic             on_top;
  } cfg_t;

endpackage

FILE: rtl/core/ntc_adc_to_celsius.sv
// Throughput: one sample per cycle while the skid buffer is free; the pipeline
// stages (four for voltage scaling, 17 for the two parallel log2 units, four
// for the denominator and 18 for the restoring divider) feed an output
// register with a one-word skid buffer.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// configuration registers with their default values.
module ntc_adc_to_celsius #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              adc_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ntc_a2c_pkg::TempW-1:0] temp_centi_celsius_o,
  output logic                                out_of_range_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ntc_a2c_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ntc_a2c_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned TW = ntc_a2c_pkg::TempW;
  localparam int unsigned QW = ntc_a2c_pkg::QuotW;
  localparam int unsigned Depth = 4 + (ntc_a2c_pkg::FracW + 1) + (4 + QW);

  ntc_a2c_pkg::cfg_t cfg_q;

  logic                           en;
  logic [Depth-1:0]               vld_q;
  logic [ntc_a2c_pkg::ProdW-1:0]  pa, pb;
  logic [ntc_a2c_pkg::LogW-1:0]   la, lb;
  logic [QW-1:0]                  quot;
  logic                           bad, big;
  logic                           force_min;
  logic signed [TW-1:0]           c_tmp, t_temp;
  logic                           t_flag;

  logic                           o_valid_q, s_valid_q;
  logic signed [TW-1:0]           o_temp_q, s_temp_q;
  logic                           o_flag_q, s_flag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_mv <= ntc_a2c_pkg::RefW'(3300);
      cfg_q.rfix   <= ntc_a2c_pkg::OhmW'(10000);
      cfg_q.r25    <= ntc_a2c_pkg::OhmW'(10000);
      cfg_q.beta   <= ntc_a2c_pkg::BetaW'(3950);
      cfg_q.on_top <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ntc_a2c_pkg::cfg_idx_e'(cfg_index_i))
        ntc_a2c_pkg::CfgRefMv: cfg_q.ref_mv <= cfg_data_i[ntc_a2c_pkg::RefW-1:0];
        ntc_a2c_pkg::CfgRfix:  cfg_q.rfix   <= cfg_data_i[ntc_a2c_pkg::OhmW-1:0];
        ntc_a2c_pkg::CfgR25:   cfg_q.r25    <= cfg_data_i[ntc_a2c_pkg::OhmW-1:0];
        ntc_a2c_pkg::CfgBeta:  cfg_q.beta   <= cfg_data_i[ntc_a2c_pkg::BetaW-1:0];
        ntc_a2c_pkg::CfgOnTop: cfg_q.on_top <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid buffer is free.
  assign en         = !s_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  ntc_a2c_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .sample_i   (adc_sample_i),
    .num_prod_o (pa),
    .den_prod_o (pb)
  );

  ntc_a2c_log2 u_log_num (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (pa),
    .log_o (la)
  );

  ntc_a2c_log2 u_log_den (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (pb),
    .log_o (lb)
  );

  ntc_a2c_div u_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .beta_i    (cfg_q.beta),
    .log_num_i (la),
    .log_den_i (lb),
    .quot_o    (quot),
    .bad_o     (bad),
    .big_o     (big)
  );

  // The user must keep the configuration static while words are in flight;
  // the block does not enforce it. Degenerate divider settings are thus judged at the tail.
  assign force_min = (cfg_q.ref_mv < ntc_a2c_pkg::RefW'(2)) || (cfg_q.rfix == '0)
                     || (cfg_q.r25 == '0);

  always_comb begin
    c_tmp = $signed({1'b0, quot}) - ntc_a2c_pkg::ZeroCCenti;
    if (force_min || bad) begin
      t_temp = ntc_a2c_pkg::TempMin;
      t_flag = 1'b1;
    end else if (big || (c_tmp > ntc_a2c_pkg::TempMax)) begin
      t_temp = ntc_a2c_pkg::TempMax;
      t_flag = 1'b1;
    end else begin
      t_temp = c_tmp;
      t_flag = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (!o_valid_q || out_ready_i) begin
      o_valid_q <= s_valid_q || vld_q[Depth-1];
      s_valid_q <= 1'b0;
    end else if (!s_valid_q && vld_q[Depth-1]) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_valid_q || out_ready_i) begin
      o_temp_q <= s_valid_q ? s_temp_q : t_temp;
      o_flag_q <= s_valid_q ? s_flag_q : t_flag;
    end else if (!s_valid_q) begin
      s_temp_q <= t_temp;
      s_flag_q <= t_flag;
    end
  end

  assign out_valid_o          = o_valid_q;
  assign temp_centi_celsius_o = o_temp_q;
  assign out_of_range_o       = o_flag_q;

endmodule

FILE: rtl/core/ntc_a2c_front.sv
module ntc_a2c_front #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  ntc_a2c_pkg::cfg_t                 cfg_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic [ntc_a2c_pkg::ProdW-1:0]     num_prod_o,
  output logic [ntc_a2c_pkg::ProdW-1:0]     den_prod_o
);

  localparam int unsigned RW = ntc_a2c_pkg::RefW;
  localparam int unsigned PW = ntc_a2c_pkg::ProdW;
  localparam longint unsigned Fs = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int unsigned XW = SAMPLE_BITS + RW;
  localparam int unsigned MW = XW + 1;
  localparam int unsigned Shift = XW + SAMPLE_BITS;
  localparam logic [XW-1:0] Half = XW'(Fs / 64'd2);
  // Reciprocal of full scale, rounded up; exact floor for every x below 2^XW.
  localparam logic [MW-1:0] Recip = MW'(((64'd1 << Shift) + Fs - 64'd1) / Fs);

  logic [XW-1:0]    x_d, x_q;
  logic [XW+MW-1:0] scaled;
  logic [RW-1:0]    v_d, v_q;
  logic [RW-1:0]    ref_m1, v_clamp;
  logic [RW-1:0]    num_d, num_q, den_d, den_q;
  logic [PW-1:0]    pa_d, pa_q, pb_d, pb_q;

  assign x_d = XW'(sample_i) * XW'(cfg_i.ref_mv) + Half;

  assign scaled = {{MW{1'b0}}, x_q} * {{XW{1'b0}}, Recip};
  assign v_d    = scaled[Shift +: RW];

  always_comb begin
    ref_m1 = cfg_i.ref_mv - RW'(1);
    if (v_q == '0) begin
      v_clamp = RW'(1);
    end else if (v_q > ref_m1) begin
      v_clamp = ref_m1;
    end else begin
      v_clamp = v_q;
    end
    if (cfg_i.on_top) begin
      num_d = cfg_i.ref_mv - v_clamp;
      den_d = v_clamp;
    end else begin
      num_d = v_clamp;
      den_d = cfg_i.ref_mv - v_clamp;
    end
  end

  assign pa_d = PW'(cfg_i.rfix) * PW'(num_q);
  assign pb_d = PW'(cfg_i.r25) * PW'(den_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      v_q   <= v_d;
      num_q <= num_d;
      den_q <= den_d;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
    end
  end

  assign num_prod_o = pa_q;
  assign den_prod_o = pb_q;

endmodule

FILE: rtl/core/ntc_a2c_log2.sv
module ntc_a2c_log2 (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ntc_a2c_pkg::ProdW-1:0] x_i,
  output logic [ntc_a2c_pkg::LogW-1:0]  log_o
);

  localparam int unsigned PW = ntc_a2c_pkg::ProdW;
  localparam int unsigned EW = ntc_a2c_pkg::ExpW;
  localparam int unsigned FW = ntc_a2c_pkg::FracW;

  logic [EW-1:0]    e_d;
  logic [30:0]      y_d;
  logic [PW+29:0]   lshift;

  logic [30:0]      y_q [0:FW];
  logic [FW-1:0]    f_q [0:FW];
  logic [EW-1:0]    e_q [0:FW];

  always_comb begin
    e_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (x_i[i]) begin
        e_d = EW'(i);
      end
    end
    lshift = {30'b0, x_i} << (EW'(30) - e_d);
    if (e_d <= EW'(30)) begin
      y_d = lshift[30:0];
    end else begin
      y_d = 31'(x_i >> (e_d - EW'(30)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0] <= y_d;
      f_q[0] <= '0;
      e_q[0] <= e_d;
    end
  end

  // One fraction bit per stage: square the mantissa and renormalize.
  for (genvar j = 0; j < FW; j++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    logic [30:0] y_n;
    logic        bit_n;

    assign sq    = {31'b0, y_q[j]} * {31'b0, y_q[j]};
    assign sh    = sq[61:30];
    assign bit_n = sh[31];
    assign y_n   = bit_n ? sh[31:1] : sh[30:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[j+1] <= y_n;
        f_q[j+1] <= {f_q[j][FW-2:0], bit_n};
        e_q[j+1] <= e_q[j];
      end
    end
  end

  assign log_o = {e_q[FW], f_q[FW]};

endmodule

FILE: rtl/core/ntc_a2c_div.sv
module ntc_a2c_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [ntc_a2c_pkg::BetaW-1:0]     beta_i,
  input  logic [ntc_a2c_pkg::LogW-1:0]      log_num_i,
  input  logic [ntc_a2c_pkg::LogW-1:0]      log_den_i,
  output logic [ntc_a2c_pkg::QuotW-1:0]     quot_o,
  output logic                              bad_o,
  output logic                              big_o
);

  localparam int unsigned LW = ntc_a2c_pkg::LogW;
  localparam int unsigned QW = ntc_a2c_pkg::QuotW;
  localparam int unsigned DW = 47;
  localparam int unsigned NW = 62;
  localparam int unsigned CW = 66;
  localparam logic [47:0] KT0Ln2Ext = 48'(ntc_a2c_pkg::KT0Ln2);

  logic signed [LW:0]   l_q;
  logic signed [47:0]   prod_q;
  logic [28:0]          nb_q, nb2_q;
  logic signed [47:0]   d_s;
  logic [DW-1:0]        d2_q;
  logic                 bad2_q;
  logic [NW-1:0]        n_d;
  logic                 big_d;

  logic [NW-1:0] r_q   [0:QW];
  logic [DW-1:0] dv_q  [0:QW];
  logic [QW-1:0] q_q   [0:QW];
  logic          bad_q [0:QW];
  logic          big_q [0:QW];

  assign d_s = $signed({2'b0, beta_i, 32'b0}) + prod_q;

  assign n_d   = {1'b0, nb2_q, 32'b0} + NW'(d2_q >> 1);
  assign big_d = {4'b0, n_d} >= {1'b0, d2_q, 18'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q      <= $signed({1'b0, log_num_i}) - $signed({1'b0, log_den_i});
      prod_q   <= $signed(KT0Ln2Ext) * 48'(l_q);
      nb_q     <= 29'(beta_i) * 29'(ntc_a2c_pkg::T0Centi);
      nb2_q    <= nb_q;
      d2_q     <= d_s[DW-1:0];
      bad2_q   <= d_s[47] || (d_s == '0);
      r_q[0]   <= n_d;
      dv_q[0]  <= d2_q;
      q_q[0]   <= '0;
      bad_q[0] <= bad2_q;
      big_q[0] <= big_d;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [CW-1:0] trial;
    logic [CW-1:0] rem;
    logic          take;

    assign trial = {{(CW-DW){1'b0}}, dv_q[j]} << (QW - 1 - j);
    assign rem   = {{(CW-NW){1'b0}}, r_q[j]};
    assign take  = rem >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= take ? NW'(rem - trial) : r_q[j];
        dv_q[j+1]  <= dv_q[j];
        q_q[j+1]   <= {q_q[j][QW-2:0], take};
        bad_q[j+1] <= bad_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  assign quot_o = q_q[QW];
  assign bad_o  = bad_q[QW];
  assign big_o  = big_q[QW];

endmodule

FILE: rtl/core/ntc_a2c_checker.sv
module ntc_a2c_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [ntc_a2c_pkg::TempW-1:0] temp_centi_celsius_o,
  input logic                                out_of_range_o
);

  // A held output word stays valid until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // The input only stalls when a finished word is waiting downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no word waiting");

  // An unflagged word lies inside the output range.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |->
      temp_centi_celsius_o >= ntc_a2c_pkg::TempMin &&
      temp_centi_celsius_o <= ntc_a2c_pkg::TempMax)
    else $error("unflagged temperature out of range");

  // A flagged word is pinned to one of the two limits.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      temp_centi_celsius_o == ntc_a2c_pkg::TempMin ||
      temp_centi_celsius_o == ntc_a2c_pkg::TempMax)
    else $error("flagged temperature is not a limit");

endmodule

bind ntc_adc_to_celsius ntc_a2c_checker u_ntc_a2c_checker (.*);
